// ===== sv/ppfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared modes, constants and small arithmetic helpers for the premultiplied
// pixel format converter.
// ----------------------------------------------------------------------------
package ppfc_pkg;

  typedef enum logic [2:0] {
    MODE_TO_ARGB8 = 3'd0,
    MODE_UNPREMUL = 3'd1,
    MODE_PREMUL   = 3'd2,
    MODE_WIDEN    = 3'd3,
    MODE_BLEND    = 3'd4
  } conv_mode_t;

  localparam int unsigned FxShift = 15;
  localparam logic [15:0] OneFx   = 16'h8000;
  localparam logic [7:0]  Max8    = 8'hFF;
  localparam int unsigned QuotW   = 8;
  localparam int unsigned NumW    = 24;
  localparam int unsigned DenW    = 16;

  // x*255 by shift and subtract
  function automatic logic [23:0] mul255(input logic [15:0] x);
    mul255 = {x, 8'h00} - {8'h00, x};
  endfunction

  // 1.15 value scaled to 8 bits, before saturation
  function automatic logic [8:0] narrow9(input logic [15:0] x);
    logic [23:0] p;
    p = mul255(x);
    narrow9 = p[23:15];
  endfunction

  // lower estimate of (x<<15)/255, at most one short
  function automatic logic [15:0] widen_est(input logic [7:0] x);
    widen_est = {1'b0, x, 7'h00} + {9'h000, x[7:1]};
  endfunction

  // fix the estimate up by one where the remainder is still 255 or more
  function automatic logic [15:0] widen_fix(input logic [7:0] x, input logic [15:0] est);
    logic [23:0] rem;
    rem = {1'b0, x, 15'h0000} - mul255(est);
    widen_fix = (rem >= 24'd255) ? est + 16'd1 : est;
  endfunction

endpackage

// ===== sv/premultiplied_pixel_format_converter_top.sv =====
// ----------------------------------------------------------------------------
// premultiplied_pixel_format_converter_top
// Converts one pixel per item between ARGB8/RGB8 and premultiplied 1.15 ARGB.
// ----------------------------------------------------------------------------
// An item is taken at every clock edge with start high; busy is always low,
// so one pixel per cycle is sustained. Each result appears on the output
// ports with done high once it has passed through the pipeline; the depth
// is set by the four-stage divider used for un-premultiplying, and
// every mode runs through the same seven stages so results stay in order.
// The receiver cannot stall. conv_mode is sampled with each item.
module premultiplied_pixel_format_converter_top
  import ppfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic [15:0] comp_a,
  input  logic [15:0] comp_r,
  input  logic [15:0] comp_g,
  input  logic [15:0] comp_b,
  input  logic [7:0]  dest_r,
  input  logic [7:0]  dest_g,
  input  logic [7:0]  dest_b,
  input  logic        last_pixel,
  output logic        done,
  output logic [15:0] out_a,
  output logic [15:0] out_r,
  output logic [15:0] out_g,
  output logic [15:0] out_b,
  output logic        alpha_zero,
  output logic        clipped,
  output logic        last_out
);

  logic [2:0] conv_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_mode <= MODE_TO_ARGB8;
    end else if (cfg_wr_en) begin
      conv_mode <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // valid, mode and last travel together down stages 1 to 6
  logic       vld  [1:6];
  logic [2:0] mode [1:6];
  logic       lst  [1:6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 6; s++) vld[s] <= 1'b0;
    end else begin
      vld[1] <= start;
      for (int s = 2; s <= 6; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    mode[1] <= conv_mode;
    lst[1]  <= last_pixel;
    for (int s = 2; s <= 6; s++) begin
      mode[s] <= mode[s-1];
      lst[s]  <= lst[s-1];
    end
  end

  // stage 1: input register
  logic [15:0] a1;
  logic [15:0] c1 [3];
  logic [7:0]  d1 [3];

  always_ff @(posedge clk) begin
    a1    <= comp_a;
    c1[0] <= comp_r;
    c1[1] <= comp_g;
    c1[2] <= comp_b;
    d1[0] <= dest_r;
    d1[1] <= dest_g;
    d1[2] <= dest_b;
  end

  // stage 2: scaling products, widening estimates, divider operands
  logic [8:0]  nar2 [4];
  logic [8:0]  src2 [3];
  logic [7:0]  dst2 [3];
  logic [15:0] west2 [3];
  logic [15:0] aest2;
  logic [7:0]  a8_2;
  logic [7:0]  c8_2 [3];
  logic [NumW-1:0] num2 [3];
  logic [DenW-1:0] den2;
  logic        ovf2 [3];
  logic        az2;

  logic [15:0] inv1;
  assign inv1 = (a1 >= OneFx) ? 16'h0000 : OneFx - a1;

  always_ff @(posedge clk) begin
    logic [23:0] tp;
    nar2[0] <= narrow9(a1);
    aest2   <= widen_est(a1[7:0]);
    a8_2    <= a1[7:0];
    den2    <= a1;
    az2     <= (a1 == 16'h0000);
    for (int i = 0; i < 3; i++) begin
      tp         = inv1 * {8'h00, d1[i]};
      nar2[i+1]  <= narrow9(c1[i]);
      src2[i]    <= narrow9(c1[i]);
      dst2[i]    <= tp[22:15];
      west2[i]   <= widen_est(c1[i][7:0]);
      c8_2[i]    <= c1[i][7:0];
      num2[i]    <= mul255(c1[i]);
      ovf2[i]    <= mul255(c1[i]) >= {a1, 8'h00};
    end
  end

  // stage 3: results of the simple modes settle here
  logic [15:0] res3 [4];
  logic        clip3;
  logic [15:0] al3;
  logic [7:0]  c8_3 [3];

  logic [15:0] res3_next [4];
  logic        clip3_next;

  always_comb begin
    logic [9:0] sum;
    for (int i = 0; i < 4; i++) res3_next[i] = '0;
    clip3_next = 1'b0;
    case (mode[2])
      MODE_TO_ARGB8: begin
        for (int i = 0; i < 4; i++) begin
          res3_next[i] = (nar2[i] > 9'd255) ? {8'h00, Max8} : {7'h00, nar2[i]};
          if (nar2[i] > 9'd255) clip3_next = 1'b1;
        end
      end
      MODE_WIDEN: begin
        res3_next[0] = OneFx;
        for (int i = 0; i < 3; i++) res3_next[i+1] = widen_fix(c8_2[i], west2[i]);
      end
      MODE_BLEND: begin
        for (int i = 0; i < 3; i++) begin
          sum = {1'b0, src2[i]} + {2'b00, dst2[i]};
          res3_next[i+1] = (sum > 10'd255) ? {8'h00, Max8} : {6'h00, sum};
          if (sum > 10'd255) clip3_next = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) res3_next[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res3  <= res3_next;
    clip3 <= clip3_next;
    al3   <= widen_fix(a8_2, aest2);
    c8_3  <= c8_2;
  end

  // stage 4: premultiply products
  logic [22:0] p4 [3];
  logic [15:0] al4;

  always_ff @(posedge clk) begin
    logic [23:0] pp;
    al4 <= al3;
    for (int i = 0; i < 3; i++) begin
      pp    = {8'h00, al3} * {16'h0000, c8_3[i]};
      p4[i] <= pp[22:0];
    end
  end

  // stage 5: reciprocal estimate of p/255
  logic [22:0] p5 [3];
  logic [14:0] qe5 [3];
  logic [15:0] al5;

  always_ff @(posedge clk) begin
    logic [38:0] pm;
    al5 <= al4;
    for (int i = 0; i < 3; i++) begin
      pm     = {16'h0000, p4[i]} * 39'd32896;
      p5[i]  <= p4[i];
      qe5[i] <= pm[37:23];
    end
  end

  // stage 6: correction of p/255; full-scale colour reaches the alpha value
  logic [15:0] q6 [3];
  logic [15:0] al6;

  always_ff @(posedge clk) begin
    logic [22:0] r;
    al6 <= al5;
    for (int i = 0; i < 3; i++) begin
      r     = p5[i] - ({qe5[i], 8'h00} - {8'h00, qe5[i]});
      q6[i] <= (r >= 23'd255) ? {1'b0, qe5[i]} + 16'd1 : {1'b0, qe5[i]};
    end
  end

  // delay lines for the stage-3 results and the divider flags
  logic [15:0] res4 [4], res5 [4], res6 [4];
  logic        clip4, clip5, clip6;
  logic        ovf3 [3], ovf4 [3], ovf5 [3], ovf6 [3];
  logic        az3, az4, az5, az6;

  always_ff @(posedge clk) begin
    res4  <= res3;  res5  <= res4;  res6  <= res5;
    clip4 <= clip3; clip5 <= clip4; clip6 <= clip5;
    ovf3  <= ovf2;  ovf4  <= ovf3;  ovf5  <= ovf4;  ovf6 <= ovf5;
    az3   <= az2;   az4   <= az3;   az5   <= az4;   az6  <= az5;
  end

  // un-premultiply: colour*255 / alpha, quotient ready at stage 6
  logic [QuotW-1:0] dq6 [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    ppfc_udiv u_div (
      .clk (clk),
      .num (num2[i]),
      .den (den2),
      .quo (dq6[i])
    );
  end

  // stage 7: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[6];
    end
  end

  always_ff @(posedge clk) begin
    last_out <= lst[6];
    case (mode[6])
      MODE_UNPREMUL: begin
        out_a      <= '0;
        out_r      <= az6 ? 16'h0000 : (ovf6[0] ? {8'h00, Max8} : {8'h00, dq6[0]});
        out_g      <= az6 ? 16'h0000 : (ovf6[1] ? {8'h00, Max8} : {8'h00, dq6[1]});
        out_b      <= az6 ? 16'h0000 : (ovf6[2] ? {8'h00, Max8} : {8'h00, dq6[2]});
        alpha_zero <= az6;
        clipped    <= !az6 && (ovf6[0] || ovf6[1] || ovf6[2]);
      end
      MODE_PREMUL: begin
        out_a      <= al6;
        out_r      <= q6[0];
        out_g      <= q6[1];
        out_b      <= q6[2];
        alpha_zero <= 1'b0;
        clipped    <= 1'b0;
      end
      default: begin
        out_a      <= res6[0];
        out_r      <= res6[1];
        out_g      <= res6[2];
        out_b      <= res6[3];
        alpha_zero <= 1'b0;
        clipped    <= clip6;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##7 done)
    else $error("item accepted without a result seven cycles later");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 7))
    else $error("result without a matching item");
  a_azero_black: assert property (@(posedge clk) disable iff (rst)
    (done && alpha_zero) |-> (out_r == 16'h0000 && out_g == 16'h0000 &&
                              out_b == 16'h0000 && !clipped))
    else $error("zero alpha gave a non-black pixel or a clip");
`endif

endmodule

// ===== sv/ppfc_udiv.sv =====
// ----------------------------------------------------------------------------
// ppfc_udiv
// Pipelined restoring divider with an 8-bit quotient; two quotient bits per
// stage, four register stages. The numerator must be below den << 8.
// ----------------------------------------------------------------------------
module ppfc_udiv
  import ppfc_pkg::*;
(
  input  logic               clk,
  input  logic [NumW-1:0]    num,
  input  logic [DenW-1:0]    den,
  output logic [QuotW-1:0]   quo
);

  localparam int unsigned Stages = QuotW / 2;

  logic [NumW-1:0]  rem  [Stages+1];
  logic [DenW-1:0]  dsr  [Stages+1];
  logic [QuotW-1:0] qacc [Stages+1];

  assign rem[0]  = num;
  assign dsr[0]  = den;
  assign qacc[0] = '0;

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [NumW-1:0]  rem_next;
    logic [QuotW-1:0] q_next;

    always_comb begin
      logic [NumW-1:0] trial;
      logic [NumW-1:0] r;
      r      = rem[k];
      q_next = qacc[k];
      for (int j = 0; j < 2; j++) begin
        trial = NumW'(dsr[k]) << (QuotW - 1 - 2 * k - j);
        if (r >= trial) begin
          r = r - trial;
          q_next[QuotW - 1 - 2 * k - j] = 1'b1;
        end
      end
      rem_next = r;
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= rem_next;
      dsr[k+1]  <= dsr[k];
      qacc[k+1] <= q_next;
    end
  end

  assign quo = qacc[Stages];

endmodule
